[rtl/core/scp_pkg.sv]
`timescale 1ns / 1ps

package scp_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE     = 2'd0,
    ACT_SHOOT_RD = 2'd1,
    ACT_CAL_RD   = 2'd2,
    ACT_NOP      = 2'd3
  } scp_action_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LETTER = 2'd1,
    MODE_DIGITS = 2'd2
  } scp_mode_t;

  typedef enum logic [2:0] {
    CMD_ANGLE    = 3'd0,
    CMD_DISTANCE = 3'd1,
    CMD_ENEMY_X  = 3'd2,
    CMD_ENEMY_Y  = 3'd3,
    CMD_SHOOT    = 3'd4,
    CMD_CAL      = 3'd5,
    CMD_NONE     = 3'd7
  } scp_cmd_t;

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_END   = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int VAL_W = 13;
  localparam int ACC_W = 16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_in;
  } scp_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] angle;
    logic [VAL_W-1:0] distance;
    logic [VAL_W-1:0] enemy_x;
    logic [VAL_W-1:0] enemy_y;
    logic             shoot_flag;
    logic             calibrate_flag;
    logic             message_done;
  } scp_out_t;

  function automatic scp_cmd_t letter_code(input logic [7:0] b);
    scp_cmd_t c;
    case (b)
      CH_A:    c = CMD_ANGLE;
      CH_D:    c = CMD_DISTANCE;
      CH_U:    c = CMD_ENEMY_X;
      CH_V:    c = CMD_ENEMY_Y;
      CH_H:    c = CMD_SHOOT;
      CH_C:    c = CMD_CAL;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

  // (10*sum mod 2^16) / 10 == sum - ceil(65536*k/10), k = wrap count of 10*sum
  function automatic logic [VAL_W-1:0] wrap_quot(input logic [16:0] sum,
                                                 input logic [3:0]  k);
    logic [16:0] sub;
    logic [16:0] res;
    case (k)
      4'd0:    sub = 17'd0;
      4'd1:    sub = 17'd6554;
      4'd2:    sub = 17'd13108;
      4'd3:    sub = 17'd19661;
      4'd4:    sub = 17'd26215;
      4'd5:    sub = 17'd32768;
      4'd6:    sub = 17'd39322;
      4'd7:    sub = 17'd45876;
      4'd8:    sub = 17'd52429;
      4'd9:    sub = 17'd58983;
      4'd10:   sub = 17'd65536;
      default: sub = 17'd0;
    endcase
    res = sum - sub;
    return res[VAL_W-1:0];
  endfunction

endpackage

[rtl/core/scp_parser.sv]
`timescale 1ns / 1ps

module scp_parser #(
  parameter int MESSAGE_LIMIT = 48,
  parameter int MAX_DIGITS    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  scp_pkg::scp_in_t item,
  output scp_pkg::scp_out_t result
);
  import scp_pkg::*;

  localparam int POS_W = $clog2(MESSAGE_LIMIT + 1);
  localparam int DC_W  = $clog2(MAX_DIGITS + 1);
  localparam logic [POS_W-1:0] LIMIT_C = POS_W'(MESSAGE_LIMIT);
  localparam logic [DC_W-1:0]  MAXD_C  = DC_W'(MAX_DIGITS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  scp_mode_t        mode_r, mode_nxt;
  scp_cmd_t         cmd_r, cmd_nxt;
  logic [DC_W-1:0]  dcnt_r, dcnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] quot_r, quot_nxt;
  logic [VAL_W-1:0] angle_r, angle_nxt;
  logic [VAL_W-1:0] dist_r, dist_nxt;
  logic [VAL_W-1:0] ex_r, ex_nxt;
  logic [VAL_W-1:0] ey_r, ey_nxt;
  logic             shoot_r, shoot_nxt;
  logic             cal_r, cal_nxt;

  logic [16:0] sum;
  logic [19:0] prod;
  logic [VAL_W-1:0] quot_new;

  assign sum      = {1'b0, acc_r} + 17'(4'(item.byte_in - CH_ZERO));
  assign prod     = {sum, 3'b000} + {2'b00, sum, 1'b0};
  assign quot_new = wrap_quot(sum, prod[19:16]);

  always_comb begin
    logic [7:0]       b;
    logic [POS_W-1:0] pos_inc;
    logic             done;
    logic             a_en, l_en;
    scp_cmd_t         a_cmd, l_cmd;
    logic [VAL_W-1:0] a_val, l_val;
    scp_cmd_t         code;
    logic             is_digit;

    b        = item.byte_in;
    pos_inc  = pos_r + 1'b1;
    code     = letter_code(b);
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    done     = 1'b0;
    a_en     = 1'b0;
    a_cmd    = cmd_r;
    a_val    = '0;
    l_en     = 1'b0;
    l_cmd    = cmd_r;
    l_val    = '0;

    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    cmd_nxt   = cmd_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    quot_nxt  = quot_r;
    angle_nxt = angle_r;
    dist_nxt  = dist_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    shoot_nxt = shoot_r;
    cal_nxt   = cal_r;

    if (scp_action_t'(item.action) == ACT_BYTE) begin
      pos_nxt = pos_inc;
      if (b == CH_END) begin
        a_en = (mode_r == MODE_LETTER);
        done = 1'b1;
      end else begin
        case (mode_r)
          MODE_LETTER: begin
            if (b == CH_COLON) begin
              mode_nxt = MODE_DIGITS;
              dcnt_nxt = '0;
              acc_nxt  = '0;
              quot_nxt = '0;
            end else begin
              a_en     = 1'b1;
              mode_nxt = (code != CMD_NONE) ? MODE_LETTER : MODE_IDLE;
              if (code != CMD_NONE) cmd_nxt = code;
            end
          end
          MODE_DIGITS: begin
            if (is_digit) begin
              acc_nxt  = prod[ACC_W-1:0];
              quot_nxt = quot_new;
              dcnt_nxt = dcnt_r + 1'b1;
              if (dcnt_r + 1'b1 >= MAXD_C) begin
                a_en     = 1'b1;
                a_val    = quot_new;
                mode_nxt = MODE_IDLE;
              end
            end else if (b == CH_SPACE) begin
              a_en     = 1'b1;
              a_val    = quot_r;
              mode_nxt = MODE_IDLE;
            end else begin
              mode_nxt = (code != CMD_NONE) ? MODE_LETTER : MODE_IDLE;
              if (code != CMD_NONE) cmd_nxt = code;
            end
          end
          default: begin
            mode_nxt = (code != CMD_NONE) ? MODE_LETTER : MODE_IDLE;
            if (code != CMD_NONE) cmd_nxt = code;
          end
        endcase
        // byte limit: the missing next byte acts as a space
        if (pos_inc >= LIMIT_C) begin
          done  = 1'b1;
          l_cmd = cmd_nxt;
          if (mode_nxt == MODE_LETTER) begin
            l_en = 1'b1;
          end else if (mode_nxt == MODE_DIGITS) begin
            l_en  = 1'b1;
            l_val = quot_nxt;
          end
        end
      end

      if (a_en) begin
        case (a_cmd)
          CMD_ANGLE:    angle_nxt = a_val;
          CMD_DISTANCE: dist_nxt  = a_val;
          CMD_ENEMY_X:  ex_nxt    = a_val;
          CMD_ENEMY_Y:  ey_nxt    = a_val;
          CMD_SHOOT:    shoot_nxt = 1'b1;
          CMD_CAL:      cal_nxt   = 1'b1;
          default:      ;
        endcase
      end
      if (l_en) begin
        case (l_cmd)
          CMD_ANGLE:    angle_nxt = l_val;
          CMD_DISTANCE: dist_nxt  = l_val;
          CMD_ENEMY_X:  ex_nxt    = l_val;
          CMD_ENEMY_Y:  ey_nxt    = l_val;
          CMD_SHOOT:    shoot_nxt = 1'b1;
          CMD_CAL:      cal_nxt   = 1'b1;
          default:      ;
        endcase
      end
      if (done) begin
        pos_nxt  = '0;
        mode_nxt = MODE_IDLE;
        cmd_nxt  = CMD_ANGLE;
        dcnt_nxt = '0;
        acc_nxt  = '0;
        quot_nxt = '0;
      end
    end

    // flags are reported after any set, before any clear
    result.angle          = angle_nxt;
    result.distance       = dist_nxt;
    result.enemy_x        = ex_nxt;
    result.enemy_y        = ey_nxt;
    result.shoot_flag     = shoot_nxt;
    result.calibrate_flag = cal_nxt;
    result.message_done   = done;

    if (scp_action_t'(item.action) == ACT_SHOOT_RD) shoot_nxt = 1'b0;
    if (scp_action_t'(item.action) == ACT_CAL_RD)   cal_nxt   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      mode_r  <= MODE_IDLE;
      cmd_r   <= CMD_ANGLE;
      dcnt_r  <= '0;
      acc_r   <= '0;
      quot_r  <= '0;
      angle_r <= '0;
      dist_r  <= '0;
      ex_r    <= '0;
      ey_r    <= '0;
      shoot_r <= 1'b0;
      cal_r   <= 1'b0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      cmd_r   <= cmd_nxt;
      dcnt_r  <= dcnt_nxt;
      acc_r   <= acc_nxt;
      quot_r  <= quot_nxt;
      angle_r <= angle_nxt;
      dist_r  <= dist_nxt;
      ex_r    <= ex_nxt;
      ey_r    <= ey_nxt;
      shoot_r <= shoot_nxt;
      cal_r   <= cal_nxt;
    end
  end

  a_pos_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < LIMIT_C)
    else $error("message position reached the limit");

  a_done_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.message_done |=> pos_r == '0 && mode_r == MODE_IDLE)
    else $error("message end did not reset the parser");

  a_digits_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DIGITS |-> dcnt_r < MAXD_C)
    else $error("digit count ran past the maximum");

  a_quot_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
    quot_r <= VAL_W'(6553))
    else $error("held value out of range");

endmodule

[rtl/core/serial_command_parser.sv]
`timescale 1ns / 1ps
// Path: the accept edge loads the input register; the parser update is then loaded
// into the result register on an edge where the output is free or out_ready is high.
// Throughput: one item per cycle unless a waiting result stalls on out_ready; the
// input register absorbs one item while a result waits on out_ready.
// Reset: synchronous active-low rst_n clears both valid flags and all parser state.

module serial_command_parser #(
  parameter int MESSAGE_LIMIT = 48,
  parameter int MAX_DIGITS    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scp_pkg::scp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output scp_pkg::scp_out_t out_data
);
  import scp_pkg::*;

  logic     in_vld_r;
  scp_in_t  in_item_r;
  logic     out_vld_r;
  scp_out_t out_item_r;
  scp_out_t res;
  logic     advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  scp_parser #(
    .MESSAGE_LIMIT(MESSAGE_LIMIT),
    .MAX_DIGITS   (MAX_DIGITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_item_r <= in_data;
    if (advance) out_item_r <= res;
  end

endmodule
